FILE: rtl/core/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  // Parser mode, one-hot
  typedef enum logic [3:0] {
    MODE_SEARCH = 4'b0001,
    MODE_HEADER = 4'b0010,
    MODE_DATA   = 4'b0100,
    MODE_SKIP   = 4'b1000
  } mode_t;

  // MPEG-1 PES header sub-phase, one-hot
  typedef enum logic [3:0] {
    VS_IDLE    = 4'b0001,
    VS_STUFF   = 4'b0010,
    VS_STD     = 4'b0100,
    VS_SKIPTAB = 4'b1000
  } vstage_t;

  // Report kinds
  localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
  localparam logic [2:0] KIND_PTS       = 3'd1;
  localparam logic [2:0] KIND_PROG_END  = 3'd2;
  localparam logic [2:0] KIND_WEIRD     = 3'd3;
  localparam logic [2:0] KIND_ELEM      = 3'd4;
  localparam logic [2:0] KIND_STUFF_OVF = 3'd5;

  // Start codes and header masks
  localparam logic [7:0]  CODE_END      = 8'hB9;
  localparam logic [7:0]  CODE_PACK     = 8'hBA;
  localparam logic [7:0]  STUFF_BYTE    = 8'hFF;
  localparam logic [23:0] PREFIX_MATCH  = 24'h000001;
  localparam logic [23:0] PREFIX_IDLE   = 24'hFFFFFF;
  localparam logic [8:0]  MPEG1_MAX_HDR = 9'd24;

  // Configuration register map
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_VIDEO_ID = 1'b0;
  localparam logic [7:0] VIDEO_ID_RESET = 8'hE0;

  // Bytes that follow the MPEG-1 timestamp field byte, by its code nibble
  function automatic logic [3:0] skip_len(input logic [3:0] nib);
    logic [3:0] r;
    unique case (nib)
      4'h2:    r = 4'd4;
      4'h3:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Rebuild PTS bits 31..0 from the five timestamp bytes
  function automatic logic [31:0] pts_pack(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [7:0] b4);
    return {b0[2:1], b1, b2[7:1], b3, b4[7:1]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/program_stream_demux.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a beat accepted into the input register is parsed from there; any
//   result it causes is written to the result register behind the out_ ports.
// Throughput: one stream byte per cycle while the result register is empty or
//   out_ready is high, set by the single parse stage between the two registers.
// Reset: synchronous, active low; parser returns to start-code search and
//   video_stream_id returns to 0xE0.
module program_stream_demux (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // stream input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_report_kind,
  output logic [7:0]       out_payload_byte,
  output logic [31:0]      out_pts_value,
  output logic             out_last_of_packet,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [psd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [7:0] vid_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == psd_pkg::REG_VIDEO_ID);
  assign prdata = (paddr[2] == psd_pkg::REG_VIDEO_ID) ? {24'd0, vid_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vid_r <= psd_pkg::VIDEO_ID_RESET;
    end else if (cfg_wr) begin
      vid_r <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------
  // Input register and result register handshake.
  // The parse stage fires when a byte sits in the input register and the
  // result register is empty or being emptied; a byte that causes no
  // result still needs the slot, which keeps ordering trivial.
  // ---------------------------------------------------------------------
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       out_v_r;
  logic       fire;

  assign fire     = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || fire;

  // ---------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------
  psd_pkg::mode_t   mode_r,   mode_nxt;
  psd_pkg::vstage_t vstage_r, vstage_nxt;
  logic [23:0] prefix_r,  prefix_nxt;
  logic [8:0]  cnt_r,     cnt_nxt;     // header byte count
  logic [8:0]  tgt_r,     tgt_nxt;     // count at which the header is examined
  logic [16:0] rem_r,     rem_nxt;     // payload / skip bytes left
  logic        fseen_r,   fseen_nxt;   // MPEG-1 timestamp field byte seen
  logic [4:0]  fbase_r,   fbase_nxt;   // header index of that field byte
  logic [7:0]  code_r,    code_nxt;

  // Captured header bytes: only these places are ever examined
  logic [7:0] h4_r, h5_r, h6_r, h7_r, h8_r, h13_r;
  logic [7:0] hv4, hv5, hv6, hv7, hv8, hv13;
  // Five timestamp bytes, base index 9 for MPEG-2, field byte for MPEG-1
  logic [7:0] pbuf_r [5];
  logic [7:0] pbuf_nxt [5];
  logic [7:0] pv [5];

  // Result of the current beat
  logic        emit;
  logic [2:0]  ekind;
  logic [7:0]  ebyte;
  logic [31:0] epts;
  logic        elast;

  logic        hdr_mode;
  logic [7:0]  byte_in;
  logic [8:0]  cnt_inc;
  logic [8:0]  poff;
  logic        pwr;
  logic        srch;        // return to start-code hunt
  logic        pes;         // PES header complete
  logic        pes_has;     // report the timestamp with it
  logic [31:0] pts_val;
  logic        mp2;
  logic [3:0]  add;
  logic [15:0] pkt_len;
  logic [16:0] total;
  logic [3:0]  nib;
  psd_pkg::vstage_t stage_eff;

  assign byte_in  = s1_byte_r;
  assign hdr_mode = (mode_r == psd_pkg::MODE_HEADER);
  assign cnt_inc  = cnt_r + 9'd1;

  // Bypass the byte being written so the examination sees it this cycle
  assign hv4  = (hdr_mode && cnt_r == 9'd4)  ? byte_in : h4_r;
  assign hv5  = (hdr_mode && cnt_r == 9'd5)  ? byte_in : h5_r;
  assign hv6  = (hdr_mode && cnt_r == 9'd6)  ? byte_in : h6_r;
  assign hv7  = (hdr_mode && cnt_r == 9'd7)  ? byte_in : h7_r;
  assign hv8  = (hdr_mode && cnt_r == 9'd8)  ? byte_in : h8_r;
  assign hv13 = (hdr_mode && cnt_r == 9'd13) ? byte_in : h13_r;

  assign poff = fseen_r ? (cnt_r - {4'd0, fbase_r}) : (cnt_r - 9'd9);
  assign pwr  = hdr_mode && (poff < 9'd5);

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      pv[k] = (pwr && poff[2:0] == 3'(k)) ? byte_in : pbuf_r[k];
    end
  end

  assign pts_val = psd_pkg::pts_pack(pv[0], pv[1], pv[2], pv[3], pv[4]);
  assign mp2     = (hv6[7:6] == 2'b10);
  assign add     = psd_pkg::skip_len(byte_in[7:4]);
  assign pkt_len = {hv4, hv5};
  assign total   = 17'd6 + {1'b0, pkt_len};
  assign nib     = pv[0][7:4];
  assign stage_eff = (cnt_inc == 9'd7) ? psd_pkg::VS_STUFF : vstage_r;

  always_comb begin
    mode_nxt   = mode_r;
    vstage_nxt = vstage_r;
    prefix_nxt = prefix_r;
    cnt_nxt    = cnt_r;
    tgt_nxt    = tgt_r;
    rem_nxt    = rem_r;
    fseen_nxt  = fseen_r;
    fbase_nxt  = fbase_r;
    code_nxt   = code_r;
    for (int k = 0; k < 5; k++) begin
      pbuf_nxt[k] = pv[k];
    end
    emit    = 1'b0;
    ekind   = psd_pkg::KIND_PAYLOAD;
    ebyte   = 8'd0;
    epts    = 32'd0;
    elast   = 1'b0;
    srch    = 1'b0;
    pes     = 1'b0;
    pes_has = 1'b0;

    unique case (mode_r)
      psd_pkg::MODE_SEARCH: begin
        if (prefix_r == psd_pkg::PREFIX_MATCH) begin
          // code byte after the prefix
          code_nxt   = byte_in;
          cnt_nxt    = 9'd4;
          vstage_nxt = psd_pkg::VS_IDLE;
          fseen_nxt  = 1'b0;
          mode_nxt   = psd_pkg::MODE_HEADER;
          if (byte_in == psd_pkg::CODE_END) begin
            srch  = 1'b1;
            emit  = 1'b1;
            ekind = psd_pkg::KIND_PROG_END;
          end else if (byte_in == psd_pkg::CODE_PACK) begin
            tgt_nxt = 9'd5;
          end else if (byte_in == vid_r) begin
            tgt_nxt = 9'd7;
          end else if (byte_in < psd_pkg::CODE_END) begin
            srch  = 1'b1;
            emit  = 1'b1;
            ekind = psd_pkg::KIND_ELEM;
          end else begin
            tgt_nxt = 9'd6;
          end
        end else begin
          prefix_nxt = {prefix_r[15:0], byte_in};
        end
      end

      psd_pkg::MODE_HEADER: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == tgt_r) begin
          if (code_r == psd_pkg::CODE_PACK) begin
            // pack header: MPEG-2 (14 + stuffing) or MPEG-1 (12)
            if (cnt_inc == 9'd5) begin
              if (hv4[7:6] == 2'b01) begin
                tgt_nxt = 9'd14;
              end else if (hv4[7:4] == 4'h2) begin
                tgt_nxt = 9'd12;
              end else begin
                srch  = 1'b1;
                emit  = 1'b1;
                ekind = psd_pkg::KIND_WEIRD;
              end
            end else if (cnt_inc == 9'd14 && hv4[7:6] == 2'b01 && hv13[2:0] != 3'd0) begin
              tgt_nxt = 9'd14 + {6'd0, hv13[2:0]};
            end else begin
              srch = 1'b1;
            end
          end else if (code_r == vid_r) begin
            if (mp2) begin
              if (cnt_inc == 9'd7) begin
                tgt_nxt = 9'd9;
              end else if (cnt_inc == 9'd9 && hv8 != 8'd0) begin
                tgt_nxt = 9'd9 + {1'b0, hv8};
              end else begin
                pes     = 1'b1;
                pes_has = hv7[7] && (hv8 >= 8'd5);
              end
            end else begin
              vstage_nxt = stage_eff;
              unique case (stage_eff)
                psd_pkg::VS_STUFF, psd_pkg::VS_STD: begin
                  if (stage_eff == psd_pkg::VS_STUFF && cnt_inc >= psd_pkg::MPEG1_MAX_HDR) begin
                    srch  = 1'b1;
                    emit  = 1'b1;
                    ekind = psd_pkg::KIND_STUFF_OVF;
                  end else if (stage_eff == psd_pkg::VS_STUFF &&
                               byte_in == psd_pkg::STUFF_BYTE) begin
                    tgt_nxt = cnt_inc + 9'd1;
                  end else if (stage_eff == psd_pkg::VS_STUFF && byte_in[7:6] == 2'b01) begin
                    // STD buffer field: two bytes
                    vstage_nxt = psd_pkg::VS_STD;
                    tgt_nxt    = cnt_inc + 9'd2;
                  end else begin
                    // timestamp field byte: remember it and where it lies
                    fseen_nxt   = 1'b1;
                    fbase_nxt   = cnt_r[4:0];
                    pbuf_nxt[0] = byte_in;
                    if (add != 4'd0) begin
                      vstage_nxt = psd_pkg::VS_SKIPTAB;
                      tgt_nxt    = cnt_inc + {5'd0, add};
                    end else begin
                      pes = 1'b1;
                    end
                  end
                end
                default: begin
                  pes     = 1'b1;
                  pes_has = fseen_r && (nib == 4'h2 || nib == 4'h3);
                end
              endcase
            end
          end else begin
            // other stream: skip by its length
            if (pkt_len == 16'd0) begin
              srch = 1'b1;
            end else begin
              mode_nxt = psd_pkg::MODE_SKIP;
              rem_nxt  = {1'b0, pkt_len};
              cnt_nxt  = 9'd0;
              tgt_nxt  = 9'd0;
            end
          end
        end
      end

      psd_pkg::MODE_DATA: begin
        emit  = 1'b1;
        ekind = psd_pkg::KIND_PAYLOAD;
        ebyte = byte_in;
        if (rem_r <= 17'd1) begin
          srch  = 1'b1;
          elast = 1'b1;
        end else begin
          rem_nxt = rem_r - 17'd1;
        end
      end

      psd_pkg::MODE_SKIP: begin
        if (rem_r <= 17'd1) begin
          srch = 1'b1;
        end else begin
          rem_nxt = rem_r - 17'd1;
        end
      end

      default: begin
        srch = 1'b1;
      end
    endcase

    // PES header done: enter payload if the length leaves any
    if (pes) begin
      if (total > {8'd0, cnt_inc}) begin
        mode_nxt   = psd_pkg::MODE_DATA;
        rem_nxt    = total - {8'd0, cnt_inc};
        cnt_nxt    = 9'd0;
        tgt_nxt    = 9'd0;
        vstage_nxt = psd_pkg::VS_IDLE;
      end else begin
        srch = 1'b1;
      end
      if (pes_has) begin
        emit  = 1'b1;
        ekind = psd_pkg::KIND_PTS;
        epts  = pts_val;
      end
    end

    // Drop back to the prefix hunt with a fresh shift register
    if (srch) begin
      mode_nxt   = psd_pkg::MODE_SEARCH;
      prefix_nxt = psd_pkg::PREFIX_IDLE;
      cnt_nxt    = 9'd0;
      tgt_nxt    = 9'd0;
      rem_nxt    = 17'd0;
      vstage_nxt = psd_pkg::VS_IDLE;
      fseen_nxt  = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      mode_r   <= psd_pkg::MODE_SEARCH;
      vstage_r <= psd_pkg::VS_IDLE;
      prefix_r <= psd_pkg::PREFIX_IDLE;
      cnt_r    <= 9'd0;
      tgt_r    <= 9'd0;
      rem_r    <= 17'd0;
      fseen_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_v_r <= 1'b1;
      end else if (fire) begin
        s1_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r  <= emit;
        mode_r   <= mode_nxt;
        vstage_r <= vstage_nxt;
        prefix_r <= prefix_nxt;
        cnt_r    <= cnt_nxt;
        tgt_r    <= tgt_nxt;
        rem_r    <= rem_nxt;
        fseen_r  <= fseen_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  logic [2:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic [31:0] out_pts_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_stream_byte;
    end
    if (fire) begin
      code_r  <= code_nxt;
      fbase_r <= fbase_nxt;
      h4_r    <= hv4;
      h5_r    <= hv5;
      h6_r    <= hv6;
      h7_r    <= hv7;
      h8_r    <= hv8;
      h13_r   <= hv13;
      for (int k = 0; k < 5; k++) begin
        pbuf_r[k] <= pbuf_nxt[k];
      end
      out_kind_r <= ekind;
      out_byte_r <= ebyte;
      out_pts_r  <= epts;
      out_last_r <= elast;
    end
  end

  assign out_valid          = out_v_r;
  assign out_report_kind    = out_kind_r;
  assign out_payload_byte   = out_byte_r;
  assign out_pts_value      = out_pts_r;
  assign out_last_of_packet = out_last_r;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import psd_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int HDR_DEPTH = 64;
  localparam int HOLD_CYCLES = 240;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES = 95;
  // Spare register slot: the block must ignore writes to it
  localparam int unsigned REG_SPARE = 1;
  // Bytes that trail the MPEG-1 timestamp field byte, by its code nibble
  localparam int unsigned TAIL_BYTES [16] = '{0, 0, 4, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [31:0] pts;
    logic        last;
  } report_t;

  // Tracks the parser state beat by beat and holds the reports still owed.
  class report_ledger;
    logic [7:0]  stream_id;
    mode_t       mode;
    logic [23:0] prefix;
    logic [8:0]  hcount;
    logic [8:0]  htarget;
    logic [7:0]  hbuf [HDR_DEPTH];
    logic [16:0] remaining;
    vstage_t     stage;
    int          pts_pos;
    report_t     due_reports [$];
    int          errors;
    int          bytes_in;
    int          kind_seen [8];

    function new();
      stream_id = VIDEO_ID_RESET;
      errors = 0;
      bytes_in = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      foreach (hbuf[k]) hbuf[k] = 8'h00;
      restart();
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    function void set_reg(input int unsigned idx, input logic [31:0] value);
      if (idx == REG_VIDEO_ID) stream_id = value[7:0];
    endfunction

    function logic [7:0] hb(input int i);
      return (i >= 0 && i < HDR_DEPTH) ? hbuf[i] : 8'h00;
    endfunction

    function void restart();
      mode = MODE_SEARCH;
      prefix = PREFIX_IDLE;
      hcount = '0;
      htarget = '0;
      remaining = '0;
      stage = VS_IDLE;
      pts_pos = 0;
    endfunction

    function void owe(input logic [2:0] kind, input logic [7:0] data,
                      input logic [31:0] pts, input logic last);
      report_t r;
      r.kind = kind;
      r.data = data;
      r.pts = pts;
      r.last = last;
      due_reports.push_back(r);
    endfunction

    // Gather PTS bits 31..0 from five timestamp bytes starting at p
    function logic [31:0] stamp(input int p);
      logic [7:0] a, b, c, d, e;
      a = hb(p);
      b = hb(p + 1);
      c = hb(p + 2);
      d = hb(p + 3);
      e = hb(p + 4);
      return {a[2:1], b, c[7:1], d, e[7:1]};
    endfunction

    function void close_header(input int c, input bit has_pts, input logic [31:0] pts);
      int total;
      total = 6 + int'({hb(4), hb(5)});
      if (total > c) begin
        mode = MODE_DATA;
        remaining = 17'(total - c);
        hcount = '0;
        htarget = '0;
        stage = VS_IDLE;
      end else begin
        restart();
      end
      if (has_pts) owe(KIND_PTS, 8'h00, pts, 1'b0);
    endfunction

    function void timestamp_field(input int c);
      logic [7:0] b;
      int unsigned add;
      b = hb(c - 1);
      add = TAIL_BYTES[b[7:4]];
      pts_pos = c;
      if (add > 0) begin
        stage = VS_SKIPTAB;
        htarget = 9'(c + int'(add));
      end else begin
        close_header(c, 1'b0, 32'd0);
      end
    endfunction

    function void video_header();
      int c;
      logic [7:0] h6, h7, h8, b;
      bit has;
      c = int'(hcount);
      h6 = hb(6);
      h7 = hb(7);
      h8 = hb(8);
      if (h6[7:6] == 2'b10) begin
        if (c == 7) begin
          htarget = 9'd9;
          return;
        end
        if (c == 9 && h8 > 0) begin
          htarget = 9'(9 + int'(h8));
          return;
        end
        has = h7[7] && h8 >= 5;
        close_header(c, has, has ? stamp(9) : 32'd0);
        return;
      end
      if (c == 7) stage = VS_STUFF;
      if (stage == VS_STUFF) begin
        if (c >= int'(MPEG1_MAX_HDR)) begin
          restart();
          owe(KIND_STUFF_OVF, 8'h00, 32'd0, 1'b0);
          return;
        end
        b = hb(c - 1);
        if (b == STUFF_BYTE) begin
          htarget = 9'(c + 1);
          return;
        end
        if (b[7:6] == 2'b01) begin
          stage = VS_STD;
          htarget = 9'(c + 2);
          return;
        end
        timestamp_field(c);
        return;
      end
      if (stage == VS_STD) begin
        timestamp_field(c);
        return;
      end
      b = hb(pts_pos - 1);
      has = (b[7:4] == 4'h2) || (b[7:4] == 4'h3);
      close_header(c, has, has ? stamp(pts_pos - 1) : 32'd0);
    endfunction

    function void header_done();
      int c;
      logic [7:0] code, m, h13;
      logic [15:0] len;
      c = int'(hcount);
      code = hb(3);
      if (code == CODE_PACK) begin
        m = hb(4);
        h13 = hb(13);
        if (c == 5) begin
          if (m[7:6] == 2'b01) htarget = 9'd14;
          else if (m[7:4] == 4'h2) htarget = 9'd12;
          else begin
            restart();
            owe(KIND_WEIRD, 8'h00, 32'd0, 1'b0);
          end
          return;
        end
        if (c == 14 && m[7:6] == 2'b01 && h13[2:0] != 3'd0) begin
          htarget = 9'd14 + 9'(h13[2:0]);
          return;
        end
        restart();
        return;
      end
      if (code == stream_id) begin
        video_header();
        return;
      end
      len = {hb(4), hb(5)};
      if (len == 16'd0) begin
        restart();
      end else begin
        mode = MODE_SKIP;
        remaining = 17'(len);
        hcount = '0;
        htarget = '0;
      end
    endfunction

    function void start_code(input logic [7:0] code);
      hbuf[0] = 8'h00;
      hbuf[1] = 8'h00;
      hbuf[2] = 8'h01;
      hbuf[3] = code;
      hcount = 9'd4;
      stage = VS_IDLE;
      pts_pos = 0;
      if (code == CODE_END) begin
        restart();
        owe(KIND_PROG_END, 8'h00, 32'd0, 1'b0);
        return;
      end
      if (code == CODE_PACK) htarget = 9'd5;
      else if (code == stream_id) htarget = 9'd7;
      else if (code < CODE_END) begin
        restart();
        owe(KIND_ELEM, 8'h00, 32'd0, 1'b0);
        return;
      end else htarget = 9'd6;
      mode = MODE_HEADER;
    endfunction

    // Note one accepted input beat and queue whatever it should produce
    function void take_byte(input logic [7:0] b);
      bytes_in++;
      case (mode)
        MODE_HEADER: begin
          if (hcount < HDR_DEPTH) hbuf[hcount] = b;
          hcount = hcount + 9'd1;
          if (hcount == htarget) header_done();
        end
        MODE_DATA: begin
          if (remaining <= 17'd1) begin
            restart();
            owe(KIND_PAYLOAD, b, 32'd0, 1'b1);
          end else begin
            remaining = remaining - 17'd1;
            owe(KIND_PAYLOAD, b, 32'd0, 1'b0);
          end
        end
        MODE_SKIP: begin
          if (remaining <= 17'd1) restart();
          else remaining = remaining - 17'd1;
        end
        default: begin
          if (prefix == PREFIX_MATCH) start_code(b);
          else prefix = {prefix[15:0], b};
        end
      endcase
    endfunction

    // Compare one result beat against the oldest report owed
    function void match_report(input logic [2:0] kind, input logic [7:0] data,
                               input logic [31:0] pts, input logic last);
      report_t want;
      if (due_reports.size() == 0) begin
        $error("unexpected report: kind %0d byte %0h pts %0h last %0b", kind, data, pts, last);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      kind_seen[want.kind]++;
      if (kind !== want.kind) begin
        $error("report_kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (data !== want.data) begin
        $error("payload_byte: expected %0h, got %0h", want.data, data);
        errors++;
      end
      if (pts !== want.pts) begin
        $error("pts_value: expected %0h, got %0h", want.pts, pts);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_packet: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_stream_byte;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_report_kind;
  logic [7:0] out_payload_byte;
  logic [31:0] out_pts_value;
  logic out_last_of_packet;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  report_ledger sb;
  logic [7:0] stim_q [$];
  logic [7:0] cur_stream_id = VIDEO_ID_RESET;
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  program_stream_demux uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_report_kind   (out_report_kind),
    .out_payload_byte  (out_payload_byte),
    .out_pts_value     (out_pts_value),
    .out_last_of_packet(out_last_of_packet),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Mostly back-to-back, sometimes a short gap, now and then a long one
  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function logic [7:0] rb();
    return 8'($urandom);
  endfunction

  function void put_code(input logic [7:0] code);
    stim_q.push_back(8'h00);
    stim_q.push_back(8'h00);
    stim_q.push_back(8'h01);
    stim_q.push_back(code);
  endfunction

  function void put_len(input int len);
    logic [15:0] l;
    l = 16'(len);
    stim_q.push_back(l[15:8]);
    stim_q.push_back(l[7:0]);
  endfunction

  // MPEG-2 pack header with 0..7 stuffing bytes
  function void gen_pack2();
    logic [2:0] nstuff;
    nstuff = 3'($urandom);
    put_code(CODE_PACK);
    stim_q.push_back({2'b01, 6'($urandom)});
    repeat (8) stim_q.push_back(rb());
    stim_q.push_back({5'($urandom), nstuff});
    repeat (nstuff) stim_q.push_back(STUFF_BYTE);
  endfunction

  function void gen_pack1();
    put_code(CODE_PACK);
    stim_q.push_back({4'h2, 4'($urandom)});
    repeat (7) stim_q.push_back(rb());
  endfunction

  // Pack marker byte that is neither MPEG-2 nor MPEG-1
  function void gen_weird();
    logic [7:0] m;
    do m = rb(); while (m[7:6] == 2'b01 || m[7:4] == 4'h2);
    put_code(CODE_PACK);
    stim_q.push_back(m);
  endfunction

  function void gen_elem();
    logic [7:0] code;
    do code = 8'($urandom_range(0, int'(CODE_END) - 1)); while (code == cur_stream_id);
    put_code(code);
  endfunction

  // Packet of some other stream, skipped by its length
  function void gen_other();
    logic [7:0] code;
    int len;
    do code = 8'($urandom_range(int'(CODE_PACK) + 1, 255)); while (code == cur_stream_id);
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
    put_code(code);
    put_len(len);
    repeat (len) stim_q.push_back(rb());
  endfunction

  // Payload length; now and then short enough to cut into the header
  function int pick_payload(input int hdr_after_len);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -$urandom_range(1, hdr_after_len);
    if (r == 1) return 0;
    return $urandom_range(1, 12);
  endfunction

  // MPEG-2 PES packet of the selected stream
  function void gen_video2();
    int hlen, pay, r;
    r = $urandom_range(0, 19);
    if (r < 10) hlen = 5;
    else if (r < 14) hlen = $urandom_range(0, 4);
    else if (r < 19) hlen = $urandom_range(6, 20);
    else hlen = $urandom_range(55, 70);
    pay = pick_payload(3 + hlen);
    put_code(cur_stream_id);
    put_len(3 + hlen + pay);
    stim_q.push_back({2'b10, 6'($urandom)});
    stim_q.push_back({($urandom_range(0, 9) < 7), 7'($urandom)});
    stim_q.push_back(8'(hlen));
    repeat (hlen) stim_q.push_back(rb());
    if (pay > 0) repeat (pay) stim_q.push_back(rb());
  endfunction

  // MPEG-1 PES packet: stuffing, optional STD field, timestamp field
  function void gen_video1();
    int nstuff, std_len, tail, pay, r;
    logic [3:0] nib;
    r = $urandom_range(0, 19);
    if (r < 16) nstuff = $urandom_range(0, 6);
    else if (r < 18) nstuff = 16;
    else nstuff = $urandom_range(17, 19);
    std_len = $urandom_range(0, 1) * 2;
    case ($urandom_range(0, 6))
      0: nib = 4'h0;
      1: nib = 4'h1;
      2: nib = 4'(4'hC + $urandom_range(0, 2));
      3, 4: nib = 4'h2;
      default: nib = 4'h3;
    endcase
    tail = int'(TAIL_BYTES[nib]);
    pay = pick_payload(nstuff + std_len + 1 + tail);
    put_code(cur_stream_id);
    put_len(nstuff + std_len + 1 + tail + pay);
    repeat (nstuff) stim_q.push_back(STUFF_BYTE);
    if (std_len > 0) begin
      stim_q.push_back({2'b01, 6'($urandom)});
      stim_q.push_back(rb());
    end
    stim_q.push_back({nib, 4'($urandom)});
    repeat (tail) stim_q.push_back(rb());
    if (pay > 0) repeat (pay) stim_q.push_back(rb());
  endfunction

  // Loose bytes, sometimes with a partial or shifted start-code prefix
  function void gen_noise();
    case ($urandom_range(0, 2))
      0: repeat ($urandom_range(1, 6)) stim_q.push_back(rb());
      1: begin
        stim_q.push_back(8'h00);
        stim_q.push_back(8'h00);
        stim_q.push_back(rb());
      end
      default: begin
        stim_q.push_back(8'h00);
        put_code(8'h00);
      end
    endcase
  endfunction

  function void build_stream(input int target);
    int r, mark, cut;
    while (stim_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 25) gen_video2();
      else if (r < 45) gen_video1();
      else if (r < 55) gen_pack2();
      else if (r < 62) gen_pack1();
      else if (r < 67) gen_weird();
      else if (r < 72) put_code(CODE_END);
      else if (r < 77) gen_elem();
      else if (r < 87) gen_other();
      else if (r < 93) gen_noise();
      else begin
        // Truncated video packet: the next start code lands inside it
        mark = stim_q.size();
        if ($urandom_range(0, 1)) gen_video2();
        else gen_video1();
        cut = $urandom_range(1, stim_q.size() - mark - 1);
        repeat (cut) void'(stim_q.pop_back());
      end
    end
  endfunction

  // Offer one beat; hold valid and payload until the block takes it
  task send_byte(input logic [7:0] b);
    int n;
    n = steady ? 0 : idle_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task send_stream();
    foreach (stim_q[k]) send_byte(stim_q[k]);
    in_valid <= 1'b0;
    stim_q.delete();
  endtask

  // Wait for every owed report, then let the block settle
  task drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(input int unsigned idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    if (idx == REG_VIDEO_ID) cur_stream_id = value[7:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Sample both handshakes at the rising edge; check results before noting input
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.match_report(out_report_kind, out_payload_byte, out_pts_value, out_last_of_packet);
      if (in_valid && in_ready) sb.take_byte(in_stream_byte);
    end
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #(400000 * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0] phase_id [4];
    phase_id = '{8'hEF, 8'hE0, 8'hC0, 8'hE7};
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stream_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: program end, weird pack, elementary codes at both ends,
    // an empty packet of another stream, then an all-ones byte
    put_code(CODE_END);
    put_code(CODE_PACK);
    stim_q.push_back(8'h9F);
    put_code(8'h00);
    put_code(CODE_END - 8'd1);
    put_code(8'hBF);
    put_len(0);
    stim_q.push_back(8'hFF);
    send_stream();
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_VIDEO_ID, {24'h0, phase_id[p]});
      // Spare slot: the selected id must not move
      if (p == 1) write_reg(REG_SPARE, 32'h0000_00EF);
      steady = (p == 1);
      build_stream(PHASE_BYTES);
      // Starve the result side while beats keep coming, so the input stalls
      if (p == 0) hold_off_req = 1'b1;
      send_stream();
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Streamed %0d bytes under ids E0, EF, E0, C0 and E7: %0d payload bytes, %0d PTS.",
             sb.bytes_in, sb.kind_seen[KIND_PAYLOAD], sb.kind_seen[KIND_PTS]);
    $display("Reports seen: program end %0d, weird pack %0d, elementary %0d, stuffing %0d.",
             sb.kind_seen[KIND_PROG_END], sb.kind_seen[KIND_WEIRD],
             sb.kind_seen[KIND_ELEM], sb.kind_seen[KIND_STUFF_OVF]);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
